[design/sce_pkg.sv]
// Package for the SCOAP controllability engine: constants, payload types, helpers.
// No dependencies.
package sce_pkg;
   localparam int NET_BITS  = 12;
   localparam int NET_COUNT = 4096;
   localparam int COST_BITS = 32;
   localparam int SLOT_BITS = NET_BITS + 1;
   localparam int QDEPTH    = 2;
   localparam logic [COST_BITS-1:0] INF_COST = {1'b1, {(COST_BITS-1){1'b0}}};

   localparam logic [1:0] REQ_SET  = 2'd0;
   localparam logic [1:0] REQ_GATE = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [3:0] K_FANOUT = 4'd0;
   localparam logic [3:0] K_BUF    = 4'd1;
   localparam logic [3:0] K_INV    = 4'd2;
   localparam logic [3:0] K_AND    = 4'd3;
   localparam logic [3:0] K_NAND   = 4'd4;
   localparam logic [3:0] K_OR     = 4'd5;
   localparam logic [3:0] K_NOR    = 4'd6;
   localparam logic [3:0] K_XOR    = 4'd7;
   localparam logic [3:0] K_XNOR   = 4'd8;
   localparam logic [3:0] K_FF     = 4'd9;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [NET_BITS-1:0] net_index;
      logic                frame;
      logic [3:0]          gate_kind;
      logic [NET_BITS-1:0] source_index;
      logic                last_source;
   } req_type_type;

   typedef struct packed {
      logic [NET_BITS-1:0]  out_net;
      logic                 out_frame;
      logic [COST_BITS-1:0] cost_zero;
      logic [COST_BITS-1:0] cost_one;
   } rsp_type_type;

   // classified operation handed from front to back
   typedef struct packed {
      logic                 do_set;
      logic                 do_read;
      logic                 do_gate;
      logic [SLOT_BITS-1:0] rd_slot;
      logic [NET_BITS-1:0]  net;
      logic                 frame;
      logic [3:0]           kind;
      logic                 last;
   } op_type;

   function automatic logic [COST_BITS-1:0] cmin(input logic [COST_BITS-1:0] x,
                                                  input logic [COST_BITS-1:0] y);
      return (x > y) ? y : x;
   endfunction
endpackage

[design/sce_front.sv]
// Front end: accepts request words, classifies them and pushes into a short queue.
// Depends on sce_pkg.
module sce_front import sce_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         op_valid,
   input  logic         op_take,
   output op_type       op
);
   op_type     q_ff [QDEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   op_type     nop;

   always_comb begin
      nop.do_set  = (req_data.req_type == REQ_SET);
      nop.do_read = (req_data.req_type == REQ_READ);
      nop.do_gate = (req_data.req_type == REQ_GATE);
      nop.net     = req_data.net_index;
      nop.frame   = req_data.frame;
      nop.kind    = req_data.gate_kind;
      nop.last    = req_data.last_source;
      nop.rd_slot = nop.do_gate ?
                    {req_data.source_index, (req_data.gate_kind == K_FF) ? 1'b0 : req_data.frame}
                  : {req_data.net_index, req_data.frame};
   end

   assign req_stall = (cnt_ff == 2'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign op_valid  = (cnt_ff != 2'd0);
   assign pop       = op_valid && op_take;
   assign op        = q_ff[rp_ff];
   assign wp_in     = push ? ~wp_ff : wp_ff;
   assign rp_in     = pop ? ~rp_ff : rp_ff;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= nop;
   end
endmodule

[design/sce_back.sv]
// Back end: cost memory, fanin accumulators, gate rules and result register.
// Depends on sce_pkg.
module sce_back import sce_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         op_valid,
   output logic         op_take,
   input  op_type       op,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type_type rsp_data
);
   typedef logic [COST_BITS-1:0] cost_type;

   logic [2*COST_BITS-1:0] mem [2*NET_COUNT];
   logic [2*COST_BITS-1:0] rdat_ff;
   logic   busy_ff, busy_in;       // stage 2 holds the op whose read is in flight
   op_type op_ff;
   cost_type mz_ff, mo_ff, az_ff, ao_ff, sz_ff, so_ff;
   logic   fz_ff, fo_ff, first_ff;
   cost_type mz_in, mo_in, az_in, ao_in, sz_in, so_in;
   logic   fz_in, fo_in, first_in;
   logic   rv_ff, rv_in;
   rsp_type_type rd_ff;
   cost_type bz, bo, wz, wo;
   logic   we, wfr, done, clr;
   cost_type g0c0, g0c1, g1c0, g1c1;

   // one op at a time: read issued, then handled; reads wait on the output register
   assign done    = busy_ff && !(op_ff.do_read && rv_ff && rsp_stall);
   assign op_take = op_valid && (!busy_ff || done);
   assign busy_in = op_take || (busy_ff && !done);
   assign bz = rdat_ff[COST_BITS-1:0];
   assign bo = rdat_ff[2*COST_BITS-1:COST_BITS];

   always_comb begin
      mz_in = mz_ff; mo_in = mo_ff; az_in = az_ff; ao_in = ao_ff;
      sz_in = sz_ff; so_in = so_ff; fz_in = fz_ff; fo_in = fo_ff; first_in = first_ff;
      we = 1'b0; wfr = op_ff.frame; wz = '0; wo = '0; clr = 1'b0;
      g0c0 = '0; g0c1 = '0; g1c0 = '0; g1c1 = '0;
      if (done && op_ff.do_set) begin
         we = 1'b1; wz = cost_type'(1); wo = cost_type'(1);
      end
      if (done && op_ff.do_gate) begin
         mz_in = first_ff ? bz : cmin(mz_ff, bz);
         mo_in = first_ff ? bo : cmin(mo_ff, bo);
         if (first_ff) begin az_in = bz; ao_in = bo; end
         if (!fz_ff) begin
            if (bz == INF_COST) begin fz_in = 1'b1; sz_in = '0; end
            else sz_in = sz_ff + bz;
         end
         if (!fo_ff) begin
            if (bo == INF_COST) begin fo_in = 1'b1; so_in = '0; end
            else so_in = so_ff + bo;
         end
         first_in = 1'b0;
         if (op_ff.last) begin
            clr = 1'b1; we = 1'b1;
            case (op_ff.kind)
               K_FANOUT: begin wz = az_in; wo = ao_in; end
               K_BUF:    begin wz = az_in + 1; wo = ao_in + 1; end
               K_INV:    begin wz = ao_in + 1; wo = az_in + 1; end
               K_AND:  begin wz = mz_in + 1; wo = (fo_in ? INF_COST : so_in) + 1; end
               K_NAND: begin wo = mz_in + 1; wz = (fo_in ? INF_COST : so_in) + 1; end
               K_OR:   begin wo = mo_in + 1; wz = (fz_in ? INF_COST : sz_in) + 1; end
               K_NOR:  begin wz = mo_in + 1; wo = (fz_in ? INF_COST : sz_in) + 1; end
               K_XOR: begin
                  g0c0 = cmin(az_in + 1, bo + 2); g0c1 = ao_in + bz + 2;
                  g1c0 = cmin(ao_in + 1, bz + 2); g1c1 = az_in + bo + 2;
                  wz = g0c0 + g1c0 + 1; wo = cmin(g0c1, g1c1) + 1;
               end
               K_XNOR: begin
                  g0c0 = cmin(az_in + 1, bz + 1); g0c1 = ao_in + bo + 1;
                  g1c0 = cmin(ao_in + 2, bo + 2); g1c1 = az_in + bz + 3;
                  wz = g0c0 + g1c0 + 1; wo = cmin(g0c1, g1c1) + 1;
               end
               K_FF: begin wfr = 1'b1; wz = az_in + 1; wo = ao_in + 1; end
               default: we = 1'b0;
            endcase
         end
      end
      rv_in = rv_ff && rsp_stall;
      if (done && op_ff.do_read) rv_in = 1'b1;
   end

   // a read of the slot being written this cycle takes the new costs
   always_ff @(posedge clock) begin
      if (op_take) rdat_ff <= (we && ({op_ff.net, wfr} == op.rd_slot)) ? {wo, wz}
                                                                        : mem[op.rd_slot];
      if (we) mem[{op_ff.net, wfr}] <= {wo, wz};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; rv_ff <= 1'b0; first_ff <= 1'b1;
         mz_ff <= '0; mo_ff <= '0; az_ff <= '0; ao_ff <= '0;
         sz_ff <= '0; so_ff <= '0; fz_ff <= 1'b0; fo_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; rv_ff <= rv_in;
         if (clr) begin
            first_ff <= 1'b1; fz_ff <= 1'b0; fo_ff <= 1'b0; sz_ff <= '0; so_ff <= '0;
            mz_ff <= '0; mo_ff <= '0; az_ff <= '0; ao_ff <= '0;
         end else begin
            first_ff <= first_in; fz_ff <= fz_in; fo_ff <= fo_in;
            sz_ff <= sz_in; so_ff <= so_in;
            mz_ff <= mz_in; mo_ff <= mo_in; az_ff <= az_in; ao_ff <= ao_in;
         end
      end
      if (op_take) op_ff <= op;
      if (done && op_ff.do_read) begin
         rd_ff.out_net   <= op_ff.net;
         rd_ff.out_frame <= op_ff.frame;
         rd_ff.cost_zero <= bz;
         rd_ff.cost_one  <= bo;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;
endmodule

[design/scoap_controllability_engine_core.sv]
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_stall | req_data (req_type_type)
// rsp     | out | rsp_valid / rsp_stall | rsp_data (rsp_type_type)
// A word waits in the two-entry queue, then the back end does a registered cost read and
// then accumulates and writes back, overlapped with the next read; the back end takes
// one word per cycle while no read waits on a stalled result.
// Reset clears control and the fanin accumulators; the cost memory is undefined until written.
// A stalled result holds the back end only on a following read.
// Depends on sce_pkg, sce_front, sce_back.
module scoap_controllability_engine_core import sce_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type_type rsp_data
);
   logic   op_valid, op_take;
   op_type op;

   sce_front u_front (.clock, .reset, .req_valid, .req_stall, .req_data,
                      .op_valid, .op_take, .op);
   sce_back  u_back  (.clock, .reset, .op_valid, .op_take, .op,
                      .rsp_valid, .rsp_stall, .rsp_data);
endmodule

[design/sce_checker.sv]
// Port-level checker for the engine, bound to the top level.
// Depends on sce_pkg.
module sce_checker import sce_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_type_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_type_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid) else $error("rsp after reset");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data)) else $error("req changed");
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({rsp_valid, req_stall})) else $error("handshake unknown");
endmodule

bind scoap_controllability_engine_core sce_checker u_chk (.*);

[dv/scoap_controllability_engine_core_tb.sv]
// Testbench for scoap_controllability_engine_core: set, gate-fanin and read words
// checked against an in-bench cost predictor. Depends on sce_pkg and the design.
module scoap_controllability_engine_core_tb;
   import sce_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 600000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_type_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_type_type rsp_data;

   scoap_controllability_engine_core u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted state
   logic [63:0] cost_mem [0:2*NET_COUNT-1];
   logic [31:0] min_zero, min_one;
   logic [32:0] sum_zero, sum_one;
   logic [63:0] first_costs;
   int unsigned fanins_seen;
   rsp_type_type expected_costs[$];

   // which slots hold a defined value
   bit written [0:2*NET_COUNT-1];
   int written_slots[$];
   int both_nets[$];

   int unsigned send_idle = 0, recv_idle = 0, hold_cycles = 0;
   int unsigned errors = 0, reads_checked = 0, cycles = 0, words_sent = 0;

   function automatic logic [31:0] lesser(logic [31:0] x, logic [31:0] y);
      return (x > y) ? y : x;
   endfunction

   function automatic logic [32:0] sum_fold(logic [32:0] s, logic [31:0] c);
      if (s[32]) return s;
      if (c == INF_COST) return 33'h1_0000_0000;
      return {1'b0, s[31:0] + c};
   endfunction

   function automatic logic [31:0] sum_final(logic [32:0] s);
      return (s[32] ? INF_COST : s[31:0]) + 32'd1;
   endfunction

   task automatic note_written(int net, int fr);
      int s;
      s = net * 2 + fr;
      if (!written[s]) begin
         written[s] = 1'b1;
         written_slots.push_back(s);
         if (written[net * 2 + (1 - fr)]) both_nets.push_back(net);
      end
   endtask

   task automatic store_costs(int net, int fr, logic [31:0] z, logic [31:0] o);
      cost_mem[net * 2 + fr] = {o, z};
      note_written(net, fr);
   endtask

   task automatic predict_word(req_type_type w);
      logic [31:0] az, ao, bz, bo, g0c0, g0c1, g1c0, g1c1;
      logic [63:0] v;
      int net, fr;
      rsp_type_type r;
      net = int'(w.net_index);
      fr  = int'(w.frame);
      case (w.req_type)
         REQ_SET: store_costs(net, fr, 32'd1, 32'd1);
         REQ_READ: begin
            v = cost_mem[net * 2 + fr];
            r.out_net = w.net_index;
            r.out_frame = w.frame;
            r.cost_zero = v[31:0];
            r.cost_one = v[63:32];
            expected_costs.push_back(r);
         end
         REQ_GATE: begin
            v = cost_mem[w.source_index * 2 + ((w.gate_kind == K_FF) ? 0 : fr)];
            bz = v[31:0];
            bo = v[63:32];
            if (fanins_seen == 0) begin
               min_zero = bz;
               min_one = bo;
               first_costs = v;
            end else begin
               min_zero = lesser(min_zero, bz);
               min_one = lesser(min_one, bo);
            end
            sum_zero = sum_fold(sum_zero, bz);
            sum_one = sum_fold(sum_one, bo);
            if (fanins_seen < 15) fanins_seen++;
            if (w.last_source) begin
               az = first_costs[31:0];
               ao = first_costs[63:32];
               case (w.gate_kind)
                  K_FANOUT: store_costs(net, fr, az, ao);
                  K_BUF:    store_costs(net, fr, az + 1, ao + 1);
                  K_INV:    store_costs(net, fr, ao + 1, az + 1);
                  K_AND:    store_costs(net, fr, min_zero + 1, sum_final(sum_one));
                  K_NAND:   store_costs(net, fr, sum_final(sum_one), min_zero + 1);
                  K_OR:     store_costs(net, fr, sum_final(sum_zero), min_one + 1);
                  K_NOR:    store_costs(net, fr, min_one + 1, sum_final(sum_zero));
                  K_XOR, K_XNOR: begin
                     if (w.gate_kind == K_XOR) begin
                        g0c0 = lesser(az + 1, bo + 2);
                        g0c1 = ao + bz + 2;
                        g1c0 = lesser(ao + 1, bz + 2);
                        g1c1 = az + bo + 2;
                     end else begin
                        g0c0 = lesser(az + 1, bz + 1);
                        g0c1 = ao + bo + 1;
                        g1c0 = lesser(ao + 2, bo + 2);
                        g1c1 = az + bz + 3;
                     end
                     store_costs(net, fr, g0c0 + g1c0 + 1, lesser(g0c1, g1c1) + 1);
                  end
                  K_FF: store_costs(net, 1, az + 1, ao + 1);
                  default: ;
               endcase
               min_zero = '0; min_one = '0; sum_zero = '0; sum_one = '0;
               first_costs = '0; fanins_seen = 0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_word(req_type_type w);
      while ($urandom_range(99) < send_idle) begin
         @(negedge clock) req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_word(w);
      words_sent++;
   endtask

   task automatic send_set(int net, int fr);
      req_type_type w;
      w = req_type_type'($urandom);
      w.req_type = REQ_SET; w.net_index = NET_BITS'(net); w.frame = 1'(fr);
      send_word(w);
   endtask

   task automatic send_read(int net, int fr);
      req_type_type w;
      w = req_type_type'($urandom);
      w.req_type = REQ_READ; w.net_index = NET_BITS'(net); w.frame = 1'(fr);
      send_word(w);
   endtask

   task automatic send_fanin(int net, int fr, logic [3:0] kind, int src, bit last);
      req_type_type w;
      w.req_type = REQ_GATE; w.net_index = NET_BITS'(net); w.frame = 1'(fr);
      w.gate_kind = kind;
      w.source_index = NET_BITS'(src); w.last_source = last;
      send_word(w);
   endtask

   task automatic read_random_slot();
      int s;
      s = written_slots[$urandom_range(written_slots.size() - 1)];
      send_read(s / 2, s % 2);
   endtask

   // a whole gate with sources drawn from nets defined in both frames
   task automatic send_random_gate(int nfan);
      logic [3:0] kind;
      int net, fr;
      kind = 4'($urandom_range(15));
      net = $urandom_range(NET_COUNT - 1);
      fr = $urandom_range(1);
      for (int i = 0; i < nfan; i++) begin
         if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) read_random_slot();
            else send_set($urandom_range(NET_COUNT - 1), $urandom_range(1));
         end
         send_fanin(net, fr, kind, both_nets[$urandom_range(both_nets.size() - 1)],
                    i == nfan - 1);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_costs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_every_kind();
      send_set(0, 0); send_set(0, 1); send_set(NET_COUNT - 1, 0);
      send_set(NET_COUNT - 1, 1);
      for (int k = 0; k < 16; k++) begin
         send_fanin(10 + k, k % 2, 4'(k), 0, 1'b0);
         send_fanin(10 + k, k % 2, 4'(k), NET_COUNT - 1, 1'b1);
         if (k <= 9) send_read(10 + k, (k == 9) ? 1 : k % 2);
      end
      send_fanin(40, 0, K_XOR, 18, 1'b1); send_read(40, 0);
      for (int i = 0; i < 17; i++) send_fanin(41, 1, K_AND, 0, i == 16);
      send_read(41, 1);
      send_word(req_type_type'({2'd3, 30'h0}));
      wait_drained();
   endtask

   // doubling chain through 2^32-1 reaches the infinite cost and the wrap to zero
   task automatic test_infinite_and_wrap();
      send_set(100, 0);
      for (int i = 0; i < 32; i++) begin
         send_fanin(101 + i, 0, K_AND, 100 + i, 1'b0);
         send_fanin(101 + i, 0, K_AND, 100 + i, 1'b1);
      end
      send_fanin(140, 0, K_BUF, 130, 1'b1); send_read(140, 0);
      send_fanin(141, 0, K_AND, 140, 1'b0);
      send_fanin(141, 0, K_AND, 100, 1'b1); send_read(141, 0);
      send_fanin(142, 0, K_NOR, 141, 1'b0);
      send_fanin(142, 0, K_NOR, 140, 1'b1); send_read(142, 0);
      send_fanin(143, 0, K_BUF, 132, 1'b1); send_read(143, 0);
      send_fanin(144, 0, K_XNOR, 132, 1'b0);
      send_fanin(144, 0, K_XNOR, 140, 1'b1); send_read(144, 0);
      wait_drained();
   endtask

   task automatic test_random_traffic(int unsigned words);
      int unsigned target;
      target = words_sent + words;
      while (words_sent < target) begin
         case ($urandom_range(9))
            0: send_set($urandom_range(NET_COUNT - 1), $urandom_range(1));
            1, 2: read_random_slot();
            3: send_word(req_type_type'({2'd3, 30'($urandom)}));
            default: send_random_gate(($urandom_range(19) == 0) ? 17 : $urandom_range(1, 4));
         endcase
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      for (int i = 0; i < 40; i++) read_random_slot();
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   always @(posedge clock) begin
      rsp_type_type e;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_costs.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %p", rsp_data);
         end else begin
            e = expected_costs.pop_front();
            reads_checked++;
            if (rsp_data.out_net !== e.out_net || rsp_data.out_frame !== e.out_frame ||
                rsp_data.cost_zero !== e.cost_zero || rsp_data.cost_one !== e.cost_one) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %p, got %p", e, rsp_data);
            end
         end
      end
   end

   initial begin
      min_zero = '0; min_one = '0; sum_zero = '0; sum_one = '0;
      first_costs = '0; fanins_seen = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      send_idle = 28; recv_idle = 56;
      test_every_kind();
      test_infinite_and_wrap();
      for (int n = 200; n < 232; n++) begin
         send_set(n, 0); send_set(n, 1);
      end
      test_random_traffic(540);
      test_backpressure();
      send_idle = 56; recv_idle = 28;
      test_random_traffic(540);
      send_idle = 0; recv_idle = 0;
      test_random_traffic(540);
      $display("%0d words sent, %0d read results checked, all gate kinds, infinite cost,",
               words_sent, reads_checked);
      $display("wrap-around, fanin saturation and a long result stall covered");
      if (errors == 0 && expected_costs.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, expected_costs.size());
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
